// File: rtl/core/assert_macros.svh
// Assertion macros used by the switch matrix scanner controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SMSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/smse_pkg.sv
// Package: request mode codes and controller/datapath interface types.
package smse_pkg;

  localparam logic [2:0] MODE_SCAN     = 3'd0;
  localparam logic [2:0] MODE_TEST     = 3'd1;
  localparam logic [2:0] MODE_TAKE_R   = 3'd2;
  localparam logic [2:0] MODE_TAKE_F   = 3'd3;
  localparam logic [2:0] MODE_READ_ROW = 3'd4;
  localparam logic [2:0] MODE_TAKE_CHG = 3'd5;
  localparam logic [2:0] MODE_DUMP     = 3'd6;
  localparam logic [2:0] MODE_CLEAR    = 3'd7;

  // Dump reports rows 0..7; this is the final one.
  localparam logic [2:0] DUMP_LAST_ROW = 3'd7;

  typedef struct packed {
    logic       capture;   // latch the incoming request
    logic       fire;      // update state and load the result register
    logic [2:0] dump_row;  // row reported by this dump step
  } smse_cmd_t;

  typedef struct packed {
    logic dump_mode;       // latched request is a dump
  } smse_stat_t;

endpackage

// File: rtl/core/switch_matrix_scanner_edges.sv
// Top level: 8-column switch matrix scanner with sticky edge flags.
// Usage:
//  - Input channel (in_valid/in_ready) carries one request: in_mode selects
//    scan, test switch, take rise, take fall, read row, take changed, dump
//    edges or clear. in_columns is the sampled column byte for scan requests.
//  - Result channel (out_valid/out_ready) returns one result per request,
//    eight for a dump (rows 0..7, out_last on the eighth).
//  - out_row_drive is the one-hot select of the row to sample next; apply it
//    to the matrix and feed the resulting column byte with the next scan.
//  - A request is latched when accepted; the controller then executes it and
//    loads the result register once that register is free. No new request is
//    taken until then. A dump reports one row per cycle, while the result
//    register is free, through the single state read port.
//  - The result register decouples the sides: the controller goes back to
//    idle once a result is loaded and takes the next request while it waits.
//    A stalled receiver holds the result and the next request waits in
//    execute until the register frees up.
//  - Reset (rst_n low, synchronous) clears all switch states, edge flags,
//    the changed flag and the row counter; no result is pending after it.
module switch_matrix_scanner_edges #(
  parameter int ROWS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_columns,
  input  logic [5:0] in_switch_number,
  input  logic [2:0] in_row_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_row_drive,
  output logic       out_bit_value,
  output logic [7:0] out_row_byte,
  output logic [7:0] out_rise_byte,
  output logic [7:0] out_fall_byte,
  output logic       out_any_edge,
  output logic       out_last
);
  import smse_pkg::*;

  smse_cmd_t  cmd;
  smse_stat_t stat;

  // handshakes, dump sequencing, result valid
  smse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // matrix state and result formation
  smse_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_columns       (in_columns),
    .in_switch_number (in_switch_number),
    .in_row_index     (in_row_index),
    .out_row_drive    (out_row_drive),
    .out_bit_value    (out_bit_value),
    .out_row_byte     (out_row_byte),
    .out_rise_byte    (out_rise_byte),
    .out_fall_byte    (out_fall_byte),
    .out_any_edge     (out_any_edge),
    .out_last         (out_last)
  );

endmodule

// File: rtl/core/smse_ctrl.sv
// Controller: request handshake, dump step counter and result valid.
`include "assert_macros.svh"

module smse_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  smse_pkg::smse_stat_t  stat,
  output smse_pkg::smse_cmd_t   cmd
);
  import smse_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic       state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.capture  = (state_r == ST_IDLE) && in_valid;
    cmd.fire     = (state_r == ST_EXEC) && out_free;
    cmd.dump_row = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (stat.dump_mode && (cnt_r != DUMP_LAST_ROW)) begin
            cnt_nxt = cnt_r + 3'd1;
          end else begin
            cnt_nxt   = 3'd0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = 3'd0;
      end
    endcase
    out_valid_nxt = cmd.fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SMSE_ASSERT_NXT(a_busy_after_capture, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted but controller stayed idle")
  `SMSE_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !cmd.fire, "pending result overwritten")
  `SMSE_ASSERT_IMP(a_cnt_in_dump, clk, rst_n, cnt_r != 3'd0, (state_r == ST_EXEC) && stat.dump_mode, "dump counter running outside a dump")

endmodule

// File: rtl/core/smse_dp.sv
// Datapath: request latch, switch/edge state, one-row read and result register.
module smse_dp #(
  parameter int ROWS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smse_pkg::smse_cmd_t  cmd,
  output smse_pkg::smse_stat_t stat,
  input  logic [2:0]           in_mode,
  input  logic [7:0]           in_columns,
  input  logic [5:0]           in_switch_number,
  input  logic [2:0]           in_row_index,
  output logic [7:0]           out_row_drive,
  output logic                 out_bit_value,
  output logic [7:0]           out_row_byte,
  output logic [7:0]           out_rise_byte,
  output logic [7:0]           out_fall_byte,
  output logic                 out_any_edge,
  output logic                 out_last
);
  import smse_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // latched request
  logic [2:0] mode_r;
  logic [7:0] cols_r;
  logic [5:0] sw_r;
  logic [2:0] ridx_r;

  // state
  logic [AW-1:0] scan_row_r, scan_row_nxt;
  logic [7:0]    states_r [ROWS];
  logic [7:0]    states_nxt [ROWS];
  logic [7:0]    rise_r [ROWS];
  logic [7:0]    rise_nxt [ROWS];
  logic [7:0]    fall_r [ROWS];
  logic [7:0]    fall_nxt [ROWS];
  logic [ROWS-1:0] pend_r, pend_nxt;
  logic          changed_r, changed_nxt;

  // one-row read
  logic [AW-1:0] addr;
  logic          addr_ok;
  logic [7:0]    st, ri, fa, diff, mask, ri_new, fa_new;
  logic [2:0]    col;

  // result
  logic          bitv;
  logic [7:0]    rowb, drive;

  assign stat.dump_mode = (mode_r == MODE_DUMP);
  assign col  = sw_r[2:0];
  assign mask = 8'b1 << col;

  always_comb begin
    addr    = scan_row_r;
    addr_ok = 1'b0;
    case (mode_r)
      MODE_SCAN: begin
        addr    = scan_row_r;
        addr_ok = 1'b1;
      end
      MODE_TEST, MODE_TAKE_R, MODE_TAKE_F: begin
        addr    = AW'(sw_r[5:3]);
        addr_ok = 5'(sw_r[5:3]) < 5'(ROWS);
      end
      MODE_READ_ROW: begin
        addr    = AW'(ridx_r);
        addr_ok = 5'(ridx_r) < 5'(ROWS);
      end
      MODE_DUMP: begin
        addr    = AW'(cmd.dump_row);
        addr_ok = 5'(cmd.dump_row) < 5'(ROWS);
      end
      default: begin
        addr    = scan_row_r;
        addr_ok = 1'b0;
      end
    endcase
  end

  assign st     = addr_ok ? states_r[addr] : 8'd0;
  assign ri     = addr_ok ? rise_r[addr]   : 8'd0;
  assign fa     = addr_ok ? fall_r[addr]   : 8'd0;
  assign diff   = st ^ cols_r;
  assign ri_new = ri | (diff & cols_r);
  assign fa_new = fa | (diff & st);

  always_comb begin
    scan_row_nxt = scan_row_r;
    states_nxt   = states_r;
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    pend_nxt     = pend_r;
    changed_nxt  = changed_r;
    bitv         = 1'b0;
    rowb         = 8'd0;
    case (mode_r)
      MODE_SCAN: begin
        states_nxt[addr] = cols_r;
        rise_nxt[addr]   = ri_new;
        fall_nxt[addr]   = fa_new;
        pend_nxt[addr]   = |(ri_new | fa_new);
        if (diff != 8'd0) begin
          changed_nxt = 1'b1;
        end
        scan_row_nxt = (scan_row_r == AW'(ROWS - 1)) ? '0 : scan_row_r + AW'(1);
      end
      MODE_TEST: begin
        bitv = st[col];
      end
      MODE_TAKE_R: begin
        bitv = ri[col];
        if (addr_ok) begin
          rise_nxt[addr] = ri & ~mask;
          pend_nxt[addr] = |((ri & ~mask) | fa);
        end
      end
      MODE_TAKE_F: begin
        bitv = fa[col];
        if (addr_ok) begin
          fall_nxt[addr] = fa & ~mask;
          pend_nxt[addr] = |(ri | (fa & ~mask));
        end
      end
      MODE_READ_ROW: begin
        rowb = st;
      end
      MODE_TAKE_CHG: begin
        bitv        = changed_r;
        changed_nxt = 1'b0;
      end
      MODE_DUMP: begin
        // the edge flags of every row, reported or not, are cleared with the final step
        if (cmd.dump_row == DUMP_LAST_ROW) begin
          for (int i = 0; i < ROWS; i++) begin
            rise_nxt[i] = 8'd0;
            fall_nxt[i] = 8'd0;
          end
          pend_nxt = '0;
        end
      end
      MODE_CLEAR: begin
        scan_row_nxt = '0;
        for (int i = 0; i < ROWS; i++) begin
          states_nxt[i] = 8'd0;
          rise_nxt[i]   = 8'd0;
          fall_nxt[i]   = 8'd0;
        end
        pend_nxt    = '0;
        changed_nxt = 1'b0;
      end
      default: begin
        bitv = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      drive[i] = (5'(scan_row_nxt) == 5'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      cols_r <= in_columns;
      sw_r   <= in_switch_number;
      ridx_r <= in_row_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
      for (int i = 0; i < ROWS; i++) begin
        states_r[i] <= 8'd0;
        rise_r[i]   <= 8'd0;
        fall_r[i]   <= 8'd0;
      end
      pend_r    <= '0;
      changed_r <= 1'b0;
    end else if (cmd.fire) begin
      scan_row_r <= scan_row_nxt;
      states_r   <= states_nxt;
      rise_r     <= rise_nxt;
      fall_r     <= fall_nxt;
      pend_r     <= pend_nxt;
      changed_r  <= changed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_row_drive <= drive;
      out_bit_value <= bitv;
      out_row_byte  <= rowb;
      out_rise_byte <= stat.dump_mode ? ri : 8'd0;
      out_fall_byte <= stat.dump_mode ? fa : 8'd0;
      out_any_edge  <= stat.dump_mode ? 1'b0 : |pend_nxt;
      out_last      <= !stat.dump_mode || (cmd.dump_row == DUMP_LAST_ROW);
    end
  end

endmodule
